### sv/bba_pkg.sv
// shared constants, status codes and a helper function of the block bitmap allocator
package bba_pkg;

   // store geometry
   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // field widths
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 13;
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int FULL_W   = CNT_W - BIT_W;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(4096);

   // request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_BLKS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   // bit position of a one-hot word
   function automatic logic [BIT_W-1:0] onehot_to_pos(input word_type oh);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (oh[i]) begin
            pos = pos | BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

### sv/bba_if.sv
// valid/ready channel interfaces for allocator requests and responses
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [11:0] block_index;

   modport source (output valid, output mode, output block_index, input ready);
   modport sink   (input valid, input mode, input block_index, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] granted_block;
   logic [1:0]  status;

   modport source (output valid, output granted_block, output status, input ready);
   modport sink   (input valid, input granted_block, input status, output ready);
endinterface

### sv/block_bitmap_allocator.sv
// first-fit block allocator over a used/free bitmap held in one synchronous memory
// an out-of-range free answers directly; any other free reads the block's word, then checks the
// bit and clears it if set; allocate scans, then writes the first free bit it found; the scan reads
// one bitmap word per cycle from word 0; one request at a time, the next is taken once the response registers
// reset: synchronous, clears the control state, marks every bitmap row as not written
// (reads as all free) and sets the block count register to 4096; no clearing pass is needed
module block_bitmap_allocator (
   input  logic                        clock,
   input  logic                        reset,
   bba_req_if.sink                     req_chan,
   bba_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [bba_pkg::CSR_W-1:0]   csr_write_data
);
   import bba_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_FCHK  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // bitmap memory with a valid bit per row
   word_type               mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]   row_valid_ff;
   word_type               rd_data_ff;
   logic                   rd_valid_ff;
   logic [WADDR_W-1:0]     rd_addr;
   logic                   wr_en;
   logic [WADDR_W-1:0]     wr_addr;
   word_type               wr_data;

   // control and datapath registers
   logic [2:0]             state_ff, state_in;
   logic [CSR_W-1:0]       csr_blocks_ff;
   logic [WADDR_W-1:0]     ptr_ff, ptr_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   word_type               word_ff, word_in;
   word_type               pick_ff, pick_in;
   logic [INDEX_W-1:0]     res_block_ff, res_block_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff;
   logic [INDEX_W-1:0]     rsp_block_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic [CNT_W-1:0]       active_cnt;
   logic [FULL_W-1:0]      full_words;
   logic [BIT_W-1:0]       rem_bits;
   logic [FULL_W-1:0]      ptr_ext;
   word_type               limit_mask;
   word_type               cur_word;
   word_type               free_bits;
   logic                   last_word;
   logic                   accept;
   logic                   slot_free;
   logic [31:0]            grant_wide;
   logic [31:0]            req_blk_wide;

   // effective block count, clamped to the store size
   always_comb begin
      if (32'(csr_blocks_ff) > 32'(MAX_BLOCKS)) begin
         active_cnt = CNT_W'(MAX_BLOCKS);
      end else begin
         active_cnt = CNT_W'(csr_blocks_ff);
      end
      full_words = active_cnt[CNT_W-1:BIT_W];
      rem_bits   = active_cnt[BIT_W-1:0];
   end

   // blocks of the current word that lie below the count
   always_comb begin
      ptr_ext = FULL_W'(ptr_ff);
      if (ptr_ext < full_words) begin
         limit_mask = '1;
      end else if (ptr_ext == full_words) begin
         limit_mask = (word_type'(1) << rem_bits) - word_type'(1);
      end else begin
         limit_mask = '0;
      end
      last_word = (ptr_ext >= full_words) || (ptr_ff == WADDR_W'(NUM_WORDS - 1));
      cur_word  = rd_valid_ff ? rd_data_ff : '0;
      free_bits = ~cur_word & limit_mask;
   end

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign slot_free     = !rsp_valid_ff || rsp_chan.ready;
   assign grant_wide    = (32'(ptr_ff) << BIT_W) | 32'(onehot_to_pos(pick_ff));
   assign req_blk_wide  = 32'(req_chan.block_index);

   // request sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      pick_in       = pick_ff;
      res_block_in  = res_block_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = word_ff | pick_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_block_in = '0;
               if (req_chan.mode == MODE_ALLOC) begin
                  rd_addr  = '0;
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end else if (req_blk_wide >= 32'(active_cnt)) begin
                  res_status_in = ST_OUT_OF_RANGE;
                  state_in      = S_DONE;
               end else begin
                  rd_addr  = WADDR_W'(req_blk_wide >> BIT_W);
                  ptr_in   = WADDR_W'(req_blk_wide >> BIT_W);
                  bit_in   = req_chan.block_index[BIT_W-1:0];
                  state_in = S_FCHK;
               end
            end
         end
         S_SCAN: begin
            rd_addr = ptr_ff + WADDR_W'(1);
            if (free_bits != '0) begin
               word_in  = cur_word;
               pick_in  = free_bits & (~free_bits + word_type'(1));
               state_in = S_WRITE;
            end else if (last_word) begin
               res_status_in = ST_OUT_OF_BLKS;
               state_in      = S_DONE;
            end else begin
               ptr_in = ptr_ff + WADDR_W'(1);
            end
         end
         S_WRITE: begin
            wr_en         = 1'b1;
            wr_data       = word_ff | pick_ff;
            res_block_in  = grant_wide[INDEX_W-1:0];
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_FCHK: begin
            if (!cur_word[bit_ff]) begin
               res_status_in = ST_DOUBLE_FREE;
            end else begin
               wr_en         = 1'b1;
               wr_data       = cur_word & ~(word_type'(1) << bit_ff);
               res_status_in = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // bitmap memory port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // row valid bits and read valid
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= row_valid_ff[rd_addr];
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // control state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_blocks_ff <= CSR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            csr_blocks_ff <= csr_write_data;
         end
         if (state_ff == S_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      pick_ff       <= pick_in;
      res_block_ff  <= res_block_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_DONE && slot_free) begin
         rsp_block_ff  <= res_block_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.granted_block = rsp_block_ff;
   assign rsp_chan.status        = rsp_status_ff;

endmodule

### sv/bba_checker.sv
// port-level checks of the block bitmap allocator and their binding
module bba_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_granted_block,
   input logic [1:0]  rsp_status
);
   import bba_pkg::*;

   // a pending response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a failed request returns block index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_block == '0)
      else $error("failed request returned a nonzero block");

   // one request at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind block_bitmap_allocator bba_port_checks u_bba_port_checks (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_granted_block (rsp_chan.granted_block),
   .rsp_status        (rsp_chan.status)
);

### test/bba_checker.sv
`timescale 1ns / 100ps
// checker for the block bitmap allocator: mirrors the bitmap, predicts each response and compares
module bba_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_mode,
   input  logic [bba_pkg::INDEX_W-1:0]    req_block_index,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [bba_pkg::INDEX_W-1:0]    rsp_granted_block,
   input  logic [bba_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_write_enable,
   input  logic [bba_pkg::CSR_W-1:0]      csr_write_data,
   output int                             mismatch_count,
   output int                             grants_pending
);
   import bba_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0]  block;
      logic [STATUS_W-1:0] status;
   } grant_type;

   // mirror of the used/free bits and of the block count register
   logic [MAX_BLOCKS-1:0] used_map;
   logic [CSR_W-1:0]      managed_blocks;
   grant_type             predicted_grants[$];

   // one line per mismatch, and count it
   task automatic report_mismatch(input string what, input int unsigned seen,
                                  input int unsigned wanted);
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $realtime, what, seen, wanted);
      mismatch_count = mismatch_count + 1;
   endtask

   // first-fit allocate or free against the mirrored bitmap
   function automatic grant_type allocate_or_release(input logic mode,
                                                     input logic [INDEX_W-1:0] idx);
      grant_type   answer;
      int unsigned span;
      bit          found;
      answer = '0;
      found  = 1'b0;
      // counts above the store size clamp to the store size
      span = (managed_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(managed_blocks);
      if (mode == MODE_ALLOC) begin
         for (int unsigned b = 0; b < span && !found; b++) begin
            if (!used_map[b]) begin
               used_map[b]  = 1'b1;
               answer.block = INDEX_W'(b);
               found        = 1'b1;
            end
         end
         answer.status = found ? ST_OK : ST_OUT_OF_BLKS;
      end else if (idx >= span) begin
         answer.status = ST_OUT_OF_RANGE;
      end else if (!used_map[idx]) begin
         answer.status = ST_DOUBLE_FREE;
      end else begin
         used_map[idx] = 1'b0;
         answer.status = ST_OK;
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      grant_type owed;
      grant_type fresh;
      if (reset) begin
         used_map       = '0;
         managed_blocks = CSR_RESET;
         predicted_grants.delete();
         mismatch_count = 0;
         grants_pending = 0;
      end else begin
         // block count write leaves the bitmap alone
         if (csr_write_enable) begin
            managed_blocks = csr_write_data;
         end
         // response against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_grants.size() == 0) begin
               report_mismatch("response with no request outstanding", rsp_status, 0);
            end else begin
               owed = predicted_grants.pop_front();
               if (rsp_granted_block !== owed.block) begin
                  report_mismatch("granted_block", rsp_granted_block, owed.block);
               end
               if (rsp_status !== owed.status) begin
                  report_mismatch("status", rsp_status, owed.status);
               end
            end
         end
         // predict the accepted request
         if (req_valid && req_ready) begin
            fresh = allocate_or_release(req_mode, req_block_index);
            predicted_grants.push_back(fresh);
         end
         grants_pending = predicted_grants.size();
      end
   end

endmodule

### test/tb_block_bitmap_allocator.sv
`timescale 1ns / 100ps
// testbench top for the block bitmap allocator: request stimulus, response stalls and verdict
module tb_block_bitmap_allocator;
   import bba_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 175;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = NUM_WORDS + 8;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;
   int               mismatch_count;
   int               grants_pending;
   int               cycle_count        = 0;
   int               sender_idle_pct    = 0;
   int               receiver_stall_pct = 0;
   logic [CSR_W-1:0] current_blocks     = CSR_RESET;

   // block count (last one drawn) and allocate share per random phase; idling is set below
   int phase_blocks [PHASES] = '{64, 1, 130, 8191, 65, 4097, 100, 0};
   int phase_alloc  [PHASES] = '{75, 55, 70, 85, 65, 60, 80, 55};

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();

   block_bitmap_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bba_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_mode          (req_chan.mode),
      .req_block_index   (req_chan.block_index),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_granted_block (rsp_chan.granted_block),
      .rsp_status        (rsp_chan.status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .grants_pending    (grants_pending)
   );

   // 10 ns clock
   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_block_bitmap_allocator NOT OK");
         $finish;
      end
   end

   // one request, with a random gap ahead of it; returns at the falling edge after accept
   task automatic send_request(input logic mode, input logic [INDEX_W-1:0] idx);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.block_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // hold off until every predicted response has come back
   task automatic drain_grants();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (grants_pending != 0) begin
         @(negedge clock);
      end
   endtask

   // block count write while the allocator is idle
   task automatic write_block_count(input logic [CSR_W-1:0] value);
      drain_grants();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      current_blocks = value;
   endtask

   // random request: frees mostly land on the low, busy blocks or around the count
   task automatic random_request(input int alloc_pct);
      int unsigned        span;
      int unsigned        pick;
      logic [INDEX_W-1:0] idx;
      span = (current_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(current_blocks);
      idx  = INDEX_W'($urandom);
      if ($urandom_range(0, 99) < alloc_pct) begin
         send_request(MODE_ALLOC, idx);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            idx = INDEX_W'($urandom_range(0, (span == 0) ? 0 : ((span > 256) ? 255 : span - 1)));
         end else if (pick < 75) begin
            idx = INDEX_W'(span + $urandom_range(0, 2) - 1);
         end
         send_request(MODE_FREE, idx);
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_ALLOC;
      req_chan.block_index = '0;
      rsp_chan.ready       = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: first fit, refill of a freed hole, double free at the reset count
      send_request(MODE_ALLOC, '0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, 12'd1);
      send_request(MODE_FREE, 12'd1);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, 12'd4095);
      send_request(MODE_FREE, 12'd0);
      send_request(MODE_ALLOC, 12'd4095);
      send_request(MODE_ALLOC, 12'hAAA);

      // directed: count lowered below used blocks, out of range and exhaustion
      write_block_count(13'd2);
      send_request(MODE_FREE, 12'd2);
      send_request(MODE_FREE, 12'd3);
      send_request(MODE_ALLOC, 12'h555);
      send_request(MODE_FREE, 12'd4095);

      // directed: count zero manages nothing
      write_block_count(13'd0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, 12'd0);

      // directed: counts above the store clamp to it, hidden bits come back
      write_block_count(13'd8191);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, 12'd2);
      send_request(MODE_FREE, 12'd4095);
      write_block_count(13'd4097);
      send_request(MODE_ALLOC, '0);

      // random phases over block counts and idling patterns
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            write_block_count(CSR_W'($urandom_range(2, 300)));
         end else begin
            write_block_count(CSR_W'(phase_blocks[p]));
         end
         case (p % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 70;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 70;
            end
            default: begin
               sender_idle_pct    = 8;
               receiver_stall_pct = 8;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the allocator has answered everything
            if (p == 2 && n == PHASE_ITEMS / 2) begin
               drain_grants();
            end
            random_request(phase_alloc[p]);
         end
      end

      drain_grants();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && grants_pending == 0) begin
         $display("tb_block_bitmap_allocator OK");
      end else begin
         $display("tb_block_bitmap_allocator NOT OK");
      end
      $finish;
   end

endmodule
